@@ design/assert_macros.svh @@
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// condition must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: condition must never hold");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication violated");
`else
`define ASSERT_NEVER(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

@@ design/cpfb_pkg.sv @@
// shared types and constants of the curve point frame builder
package cpfb_pkg;

   localparam int MAX_POINTS_DEF = 4096;
   localparam int INDEX_W        = 12;
   localparam int COORD_W        = 32;
   localparam int VEC_W          = 16;
   localparam int WIDE_W         = 48;
   localparam int UNIT_Q14       = 16384;
   localparam int QUEUE_DEPTH    = 2;
   localparam int NEAR_MAX       = 4;
   localparam int NEAR_SQ        = 19;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [VEC_W-1:0]   comp_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;

   // one frame to build: the two points of the difference and the normal hint
   typedef struct packed {
      coord_type [2:0]    prev;
      coord_type [2:0]    next;
      comp_type [2:0]     nrm;
      logic               present;
      logic [INDEX_W-1:0] index;
      logic               last;
   } frame_job_type;

   // one finished frame
   typedef struct packed {
      comp_type [2:0]     tan;
      comp_type [2:0]     nrm;
      comp_type [2:0]     bin;
      logic [INDEX_W-1:0] index;
      logic               last;
   } frame_type;

endpackage

@@ design/cpfb_front.sv @@
// front end: takes point beats, keeps the curve window and issues frame jobs
module cpfb_front #(
   parameter int MAX_POINTS = cpfb_pkg::MAX_POINTS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cpfb_pkg::coord_type       req_point_x,
   input  cpfb_pkg::coord_type       req_point_y,
   input  cpfb_pkg::coord_type       req_point_z,
   input  cpfb_pkg::comp_type        req_given_normal_x,
   input  cpfb_pkg::comp_type        req_given_normal_y,
   input  cpfb_pkg::comp_type        req_given_normal_z,
   input  logic                      req_normal_present,
   input  logic                      req_final_point,
   input  logic                      q_full,
   output logic                      push_valid,
   output cpfb_pkg::frame_job_type   push_job
);

   localparam int IdxMax = (1 << cpfb_pkg::INDEX_W) - 1;
   localparam int CapInt = (MAX_POINTS - 1 < IdxMax) ? MAX_POINTS - 1 : IdxMax;
   localparam logic [cpfb_pkg::INDEX_W-1:0] IndexCap = cpfb_pkg::INDEX_W'(CapInt);

   cpfb_pkg::coord_type [2:0]       before_ff;
   cpfb_pkg::coord_type [2:0]       held_ff;
   cpfb_pkg::comp_type [2:0]        nrm_ff;
   logic                            present_ff;
   logic [cpfb_pkg::INDEX_W-1:0]    index_ff;
   logic                            valid_ff;
   cpfb_pkg::frame_job_type         pend_ff;
   logic                            pend_valid_ff;

   cpfb_pkg::coord_type [2:0]       pt;
   cpfb_pkg::comp_type [2:0]        nv;
   logic [cpfb_pkg::INDEX_W-1:0]    next_index;
   cpfb_pkg::frame_job_type         job_now;
   cpfb_pkg::frame_job_type         job_last;
   logic                            accept;
   logic                            pend_push;

   assign pt = {req_point_z, req_point_y, req_point_x};
   assign nv = {req_given_normal_z, req_given_normal_y, req_given_normal_x};

   // one pending second frame or a full queue holds the input
   assign req_stall = pend_valid_ff | q_full;
   assign accept    = req_valid & ~req_stall;
   assign pend_push = pend_valid_ff & ~q_full;

   assign next_index = (index_ff < IndexCap) ? index_ff + 1'b1 : IndexCap;

   // frame of the held point, and frame of a final point
   always_comb begin
      job_now.prev    = before_ff;
      job_now.next    = pt;
      job_now.nrm     = nrm_ff;
      job_now.present = present_ff;
      job_now.index   = index_ff;
      job_now.last    = 1'b0;
      job_last.prev    = held_ff;
      job_last.next    = pt;
      job_last.nrm     = nv;
      job_last.present = req_normal_present;
      job_last.index   = next_index;
      job_last.last    = 1'b1;
   end

   assign push_valid = pend_push | (accept & valid_ff);
   assign push_job   = pend_valid_ff ? pend_ff : job_now;

   // window control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (pend_push) begin
            pend_valid_ff <= 1'b0;
         end
         if (accept) begin
            if (!valid_ff) begin
               valid_ff <= ~req_final_point;
            end else if (req_final_point) begin
               valid_ff      <= 1'b0;
               pend_valid_ff <= 1'b1;
            end
         end
      end
   end

   // window payload
   always_ff @(posedge clock) begin
      if (accept) begin
         if (!valid_ff) begin
            before_ff  <= pt;
            held_ff    <= pt;
            nrm_ff     <= nv;
            present_ff <= req_normal_present;
            index_ff   <= '0;
         end else if (req_final_point) begin
            pend_ff <= job_last;
         end else begin
            before_ff  <= held_ff;
            held_ff    <= pt;
            nrm_ff     <= nv;
            present_ff <= req_normal_present;
            index_ff   <= next_index;
         end
      end
   end

endmodule

@@ design/cpfb_queue.sv @@
// short job queue between the front end and the frame engine
module cpfb_queue #(
   parameter int DEPTH = cpfb_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  cpfb_pkg::frame_job_type   push_job,
   output logic                      full,
   input  logic                      pop,
   output logic                      empty,
   output cpfb_pkg::frame_job_type   head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

   cpfb_pkg::frame_job_type slot_ff [DEPTH];
   logic [AW-1:0]           wr_ptr_ff;
   logic [AW-1:0]           rd_ptr_ff;
   logic [CW-1:0]           count_ff;
   logic                    do_push;
   logic                    do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push_valid & ~full;
   assign do_pop  = pop & ~empty;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ design/cpfb_norm.sv @@
// shared normalizer: scale, sum of squares, square root, per-component divide
module cpfb_norm (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  cpfb_pkg::wide_type [2:0]     vec_in,
   output logic                         done,
   output cpfb_pkg::comp_type [2:0]     unit_out
);

   typedef enum logic [2:0] {
      N_IDLE, N_SCALE, N_SQUARE, N_ROOT, N_LOAD, N_STEP
   } norm_state_type;

   norm_state_type               state_ff;
   logic [2:0][47:0]             mag_ff;
   logic [2:0]                   neg_ff;
   logic [63:0]                  sum_ff;
   logic [63:0]                  x_ff;
   logic [63:0]                  r_ff;
   logic [63:0]                  bit_ff;
   logic [31:0]                  len_ff;
   logic [31:0]                  rem_ff;
   logic [14:0]                  lo_ff;
   logic [14:0]                  q_ff;
   logic [3:0]                   cnt_ff;
   logic [1:0]                   k_ff;
   cpfb_pkg::comp_type [2:0]     unit_ff;
   logic                         done_ff;

   logic [47:0]                  mx;
   logic [29:0]                  sq_arg;
   logic [59:0]                  sq;
   logic [63:0]                  root_try;
   logic                         root_ge;
   logic [63:0]                  r_next;
   logic [44:0]                  num;
   logic [32:0]                  trial;
   logic                         div_ge;
   logic [14:0]                  q_next;

   assign done     = done_ff;
   assign unit_out = unit_ff;

   // largest magnitude
   always_comb begin
      mx = mag_ff[0];
      if (mag_ff[1] > mx) mx = mag_ff[1];
      if (mag_ff[2] > mx) mx = mag_ff[2];
   end

   // square, root step and divide step
   assign sq_arg   = mag_ff[k_ff][29:0];
   assign sq       = sq_arg * sq_arg;
   assign root_try = r_ff + bit_ff;
   assign root_ge  = (x_ff >= root_try);
   assign r_next   = root_ge ? (r_ff >> 1) + bit_ff : (r_ff >> 1);
   assign num      = {1'b0, mag_ff[k_ff][29:0], 14'b0} + 45'(len_ff >> 1);
   assign trial    = {rem_ff, lo_ff[14]};
   assign div_ge   = (trial >= {1'b0, len_ff});
   assign q_next   = {q_ff[13:0], div_ge};

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            N_IDLE: begin
               if (start) begin
                  for (int i = 0; i < 3; i++) begin
                     neg_ff[i] <= vec_in[i][47];
                     mag_ff[i] <= vec_in[i][47] ? 48'(-vec_in[i]) : 48'(vec_in[i]);
                  end
                  state_ff <= N_SCALE;
               end
            end
            N_SCALE: begin
               if (mx == '0) begin
                  unit_ff  <= '0;
                  done_ff  <= 1'b1;
                  state_ff <= N_IDLE;
               end else if (mx[47:34] != '0) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 4;
               end else if (mx[47:30] != '0) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
               end else if (mx[29:25] == '0) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 4;
               end else if (!mx[29]) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
               end else begin
                  sum_ff   <= '0;
                  k_ff     <= '0;
                  state_ff <= N_SQUARE;
               end
            end
            N_SQUARE: begin
               sum_ff <= sum_ff + 64'(sq);
               if (k_ff == 2'd2) begin
                  x_ff     <= sum_ff + 64'(sq);
                  r_ff     <= '0;
                  bit_ff   <= 64'd1 << 62;
                  state_ff <= N_ROOT;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            N_ROOT: begin
               if (root_ge) x_ff <= x_ff - root_try;
               r_ff   <= r_next;
               bit_ff <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  len_ff   <= r_next[31:0];
                  k_ff     <= '0;
                  state_ff <= N_LOAD;
               end
            end
            N_LOAD: begin
               rem_ff   <= 32'(num[44:15]);
               lo_ff    <= num[14:0];
               q_ff     <= '0;
               cnt_ff   <= 4'd14;
               state_ff <= N_STEP;
            end
            N_STEP: begin
               rem_ff <= div_ge ? 32'(trial - {1'b0, len_ff}) : trial[31:0];
               lo_ff  <= lo_ff << 1;
               q_ff   <= q_next;
               if (cnt_ff == '0) begin
                  unit_ff[k_ff] <= neg_ff[k_ff] ? -$signed({1'b0, q_next})
                                                : $signed({1'b0, q_next});
                  if (k_ff == 2'd2) begin
                     done_ff  <= 1'b1;
                     state_ff <= N_IDLE;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= N_LOAD;
                  end
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            default: state_ff <= N_IDLE;
         endcase
      end
   end

endmodule

@@ design/cpfb_engine.sv @@
// back end: builds one frame per job on the shared normalizer
module cpfb_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_empty,
   input  cpfb_pkg::frame_job_type   head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cpfb_pkg::frame_type       rsp_frame
);

   typedef enum logic [3:0] {
      E_IDLE, E_TAN, E_TAN_W, E_NRM, E_NRM_W, E_DOT, E_RES,
      E_ORTH, E_ORTH_W, E_CROSS, E_BIN, E_BIN_W, E_DONE
   } eng_state_type;

   eng_state_type                state_ff;
   cpfb_pkg::frame_job_type      job_ff;
   cpfb_pkg::comp_type [2:0]     t_ff;
   cpfb_pkg::comp_type [2:0]     n_ff;
   cpfb_pkg::comp_type [2:0]     b_ff;
   logic signed [33:0]           dot_ff;
   cpfb_pkg::wide_type [2:0]     r_ff;
   cpfb_pkg::wide_type [2:0]     c_ff;
   logic [1:0]                   cnt_ff;
   cpfb_pkg::frame_type          out_ff;
   logic                         out_valid_ff;

   logic                         norm_start;
   logic                         norm_done;
   cpfb_pkg::wide_type [2:0]     norm_vec;
   cpfb_pkg::comp_type [2:0]     norm_unit;
   logic [15:0]                  ax, ay, az;
   logic signed [31:0]           dot_prod;
   logic signed [49:0]           dt;
   logic signed [49:0]           nsh;
   logic signed [31:0]           pa, pb;
   logic signed [32:0]           cd;
   logic                         small_all;
   logic signed [7:0]            r0s, r1s, r2s;
   logic [7:0]                   sqsum;
   logic                         near_zero;
   logic                         out_load;

   assign pop       = (state_ff == E_IDLE) & ~q_empty;
   assign rsp_valid = out_valid_ff;
   assign rsp_frame = out_ff;
   assign out_load  = (state_ff == E_DONE) & (~out_valid_ff | ~rsp_stall);

   // component magnitudes of the tangent for the axis fallback
   assign ax = t_ff[0][15] ? 16'(-t_ff[0]) : 16'(t_ff[0]);
   assign ay = t_ff[1][15] ? 16'(-t_ff[1]) : 16'(t_ff[1]);
   assign az = t_ff[2][15] ? 16'(-t_ff[2]) : 16'(t_ff[2]);

   // near-zero test of the orthogonalized normal
   assign small_all = (r_ff[0] >= -cpfb_pkg::NEAR_MAX) && (r_ff[0] <= cpfb_pkg::NEAR_MAX) &&
                      (r_ff[1] >= -cpfb_pkg::NEAR_MAX) && (r_ff[1] <= cpfb_pkg::NEAR_MAX) &&
                      (r_ff[2] >= -cpfb_pkg::NEAR_MAX) && (r_ff[2] <= cpfb_pkg::NEAR_MAX);
   assign r0s   = r_ff[0][7:0];
   assign r1s   = r_ff[1][7:0];
   assign r2s   = r_ff[2][7:0];
   assign sqsum = 8'(r0s * r0s) + 8'(r1s * r1s) + 8'(r2s * r2s);
   assign near_zero = small_all && (sqsum <= 8'(cpfb_pkg::NEAR_SQ));

   // normalizer operand select
   always_comb begin
      norm_vec   = '0;
      norm_start = 1'b0;
      case (state_ff)
         E_TAN: begin
            norm_start = 1'b1;
            for (int i = 0; i < 3; i++) begin
               norm_vec[i] = cpfb_pkg::WIDE_W'($signed(job_ff.next[i])) -
                             cpfb_pkg::WIDE_W'($signed(job_ff.prev[i]));
            end
         end
         E_NRM: begin
            norm_start = 1'b1;
            if (job_ff.present) begin
               for (int i = 0; i < 3; i++) begin
                  norm_vec[i] = cpfb_pkg::WIDE_W'($signed(job_ff.nrm[i]));
               end
            end else if (ax <= ay && ax <= az) begin
               norm_vec[0] = cpfb_pkg::WIDE_W'(cpfb_pkg::UNIT_Q14);
            end else if (ay <= az) begin
               norm_vec[1] = cpfb_pkg::WIDE_W'(cpfb_pkg::UNIT_Q14);
            end else begin
               norm_vec[2] = cpfb_pkg::WIDE_W'(cpfb_pkg::UNIT_Q14);
            end
         end
         E_ORTH: begin
            norm_start = ~near_zero;
            norm_vec   = r_ff;
         end
         E_BIN: begin
            norm_start = 1'b1;
            norm_vec   = c_ff;
         end
         default: begin
            norm_start = 1'b0;
         end
      endcase
   end

   // dot product term, projection removal and cross product terms
   assign dot_prod = $signed(t_ff[cnt_ff]) * $signed(n_ff[cnt_ff]);
   assign dt       = dot_ff * $signed(t_ff[cnt_ff]);
   assign nsh      = 50'($signed(n_ff[cnt_ff])) <<< 28;

   always_comb begin
      case (cnt_ff)
         2'd0: begin
            pa = $signed(t_ff[1]) * $signed(n_ff[2]);
            pb = $signed(t_ff[2]) * $signed(n_ff[1]);
         end
         2'd1: begin
            pa = $signed(t_ff[2]) * $signed(n_ff[0]);
            pb = $signed(t_ff[0]) * $signed(n_ff[2]);
         end
         default: begin
            pa = $signed(t_ff[0]) * $signed(n_ff[1]);
            pb = $signed(t_ff[1]) * $signed(n_ff[0]);
         end
      endcase
   end
   assign cd = pa - pb;

   cpfb_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .start    (norm_start),
      .vec_in   (norm_vec),
      .done     (norm_done),
      .unit_out (norm_unit)
   );

   // frame sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= E_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         // result valid: set on load, cleared once taken
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            E_IDLE: begin
               if (!q_empty) begin
                  job_ff   <= head;
                  state_ff <= E_TAN;
               end
            end
            E_TAN: state_ff <= E_TAN_W;
            E_TAN_W: begin
               if (norm_done) begin
                  t_ff     <= norm_unit;
                  state_ff <= E_NRM;
               end
            end
            E_NRM: state_ff <= E_NRM_W;
            E_NRM_W: begin
               if (norm_done) begin
                  n_ff     <= norm_unit;
                  dot_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= E_DOT;
               end
            end
            E_DOT: begin
               dot_ff <= dot_ff + 34'(dot_prod);
               if (cnt_ff == 2'd2) begin
                  cnt_ff   <= '0;
                  state_ff <= E_RES;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            E_RES: begin
               r_ff[cnt_ff] <= cpfb_pkg::WIDE_W'(nsh - dt);
               if (cnt_ff == 2'd2) begin
                  cnt_ff   <= '0;
                  state_ff <= E_ORTH;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            E_ORTH: begin
               if (near_zero) begin
                  n_ff     <= '0;
                  cnt_ff   <= '0;
                  state_ff <= E_CROSS;
               end else begin
                  state_ff <= E_ORTH_W;
               end
            end
            E_ORTH_W: begin
               if (norm_done) begin
                  n_ff     <= norm_unit;
                  cnt_ff   <= '0;
                  state_ff <= E_CROSS;
               end
            end
            E_CROSS: begin
               c_ff[cnt_ff] <= cpfb_pkg::WIDE_W'(cd);
               if (cnt_ff == 2'd2) begin
                  cnt_ff   <= '0;
                  state_ff <= E_BIN;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            E_BIN: state_ff <= E_BIN_W;
            E_BIN_W: begin
               if (norm_done) begin
                  b_ff     <= norm_unit;
                  state_ff <= E_DONE;
               end
            end
            E_DONE: begin
               if (out_load) begin
                  out_ff.tan   <= t_ff;
                  out_ff.nrm   <= n_ff;
                  out_ff.bin   <= b_ff;
                  out_ff.index <= job_ff.index;
                  out_ff.last  <= job_ff.last;
                  state_ff     <= E_IDLE;
               end
            end
            default: state_ff <= E_IDLE;
         endcase
      end
   end

endmodule

@@ design/curve_point_frame_builder_top.sv @@
// curve point frame builder: one orthonormal frame per point of a curve of two or more points
// the back end finishes one job before it pops the next, running the shared normalizer
//   up to four times per frame; zero vectors cut their normalization short
// the front end takes a point beat per cycle while the two-entry job queue has room
//   and no second frame of a final point waits to be pushed
// synchronous reset clears control state only; no clearing pass
`include "assert_macros.svh"
module curve_point_frame_builder_top #(
   parameter int MAX_POINTS = cpfb_pkg::MAX_POINTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [31:0]                 req_point_x,
   input  logic signed [31:0]                 req_point_y,
   input  logic signed [31:0]                 req_point_z,
   input  logic signed [15:0]                 req_given_normal_x,
   input  logic signed [15:0]                 req_given_normal_y,
   input  logic signed [15:0]                 req_given_normal_z,
   input  logic                               req_normal_present,
   input  logic                               req_final_point,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [15:0]                 rsp_tangent_x,
   output logic signed [15:0]                 rsp_tangent_y,
   output logic signed [15:0]                 rsp_tangent_z,
   output logic signed [15:0]                 rsp_frame_normal_x,
   output logic signed [15:0]                 rsp_frame_normal_y,
   output logic signed [15:0]                 rsp_frame_normal_z,
   output logic signed [15:0]                 rsp_binormal_x,
   output logic signed [15:0]                 rsp_binormal_y,
   output logic signed [15:0]                 rsp_binormal_z,
   output logic [11:0]                        rsp_point_index,
   output logic                               rsp_last_frame
);

   logic                      push_valid;
   cpfb_pkg::frame_job_type   push_job;
   logic                      q_full;
   logic                      q_empty;
   logic                      q_pop;
   cpfb_pkg::frame_job_type   q_head;
   cpfb_pkg::frame_type       frame;
   logic                      tan_x_in_range;

   cpfb_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .req_point_z        (req_point_z),
      .req_given_normal_x (req_given_normal_x),
      .req_given_normal_y (req_given_normal_y),
      .req_given_normal_z (req_given_normal_z),
      .req_normal_present (req_normal_present),
      .req_final_point    (req_final_point),
      .q_full             (q_full),
      .push_valid         (push_valid),
      .push_job           (push_job)
   );

   cpfb_queue #(.DEPTH(cpfb_pkg::QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   cpfb_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head      (q_head),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_frame (frame)
   );

   // result beat fields
   assign rsp_tangent_x      = frame.tan[0];
   assign rsp_tangent_y      = frame.tan[1];
   assign rsp_tangent_z      = frame.tan[2];
   assign rsp_frame_normal_x = frame.nrm[0];
   assign rsp_frame_normal_y = frame.nrm[1];
   assign rsp_frame_normal_z = frame.nrm[2];
   assign rsp_binormal_x     = frame.bin[0];
   assign rsp_binormal_y     = frame.bin[1];
   assign rsp_binormal_z     = frame.bin[2];
   assign rsp_point_index    = frame.index;
   assign rsp_last_frame     = frame.last;

   // unit range of the tangent x component
   assign tan_x_in_range = (rsp_tangent_x >= -16'sd16384) && (rsp_tangent_x <= 16'sd16384);

   // checks
   `ASSERT_NEVER(a_queue_overflow, clock, reset, push_valid && q_full)
   `ASSERT_NEVER(a_queue_underflow, clock, reset, q_pop && q_empty)
   `ASSERT_IMPLIES(a_tangent_range, clock, reset, rsp_valid, tan_x_in_range)

endmodule

@@ dv/tb_curve_point_frame_builder_top.sv @@
// testbench of the curve point frame builder: directed table, random curves, frame predictor
module tb_curve_point_frame_builder_top;

   localparam int INDEX_CAP    = 4095;
   localparam int RANDOM_BEATS = 1330;
   localparam int HOLD_OFF     = 3000;
   localparam longint LIMIT    = 5_000_000;
   localparam longint SCALE28  = 268435456;

   typedef logic signed [2:0][63:0] wvec_type;
   typedef cpfb_pkg::comp_type [2:0] uvec_type;

   // one point beat of the stimulus, with frames typed in where obvious
   typedef struct {
      cpfb_pkg::coord_type [2:0] pt;
      uvec_type                  nrm;
      logic                      present;
      logic                      fin;
      int                        nwant;
      cpfb_pkg::frame_type       want [2];
   } point_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_stall;
   logic signed [31:0] req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic signed [15:0] req_given_normal_x = '0, req_given_normal_y = '0;
   logic signed [15:0] req_given_normal_z = '0;
   logic req_normal_present = 1'b0, req_final_point = 1'b0;
   logic rsp_valid, rsp_stall = 1'b0;
   logic signed [15:0] rsp_tangent_x, rsp_tangent_y, rsp_tangent_z;
   logic signed [15:0] rsp_frame_normal_x, rsp_frame_normal_y, rsp_frame_normal_z;
   logic signed [15:0] rsp_binormal_x, rsp_binormal_y, rsp_binormal_z;
   logic [11:0] rsp_point_index;
   logic rsp_last_frame;

   curve_point_frame_builder_top DUT (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: the point before, the held point and its normal hint
   wvec_type  prior_pt, held_pt;
   uvec_type  held_nrm;
   logic      held_present, holding;
   int        held_idx;
   cpfb_pkg::frame_type expected_frames[$];
   point_beat_type plan[$];

   int     phase = 0;
   int     hold_left = 0;
   longint cycles = 0;
   int     mismatches = 0, frames_checked = 0, beats_sent = 0, curves_sent = 0;

   function automatic logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // scale to [2^29, 2^30), floor root, rounded division per component
   function automatic uvec_type unit_vec(wvec_type v);
      logic [63:0] m [3];
      logic        neg [3];
      logic [63:0] mx, s, len, q;
      uvec_type    u;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i][63];
         m[i] = neg[i] ? -v[i] : v[i];
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) return '0;
      while (mx >= 64'h4000_0000) begin
         mx = mx >> 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (mx < 64'h2000_0000) begin
         mx = mx << 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      len = floor_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         q = (m[i] * cpfb_pkg::UNIT_Q14 + len / 2) / len;
         u[i] = neg[i] ? -q[15:0] : q[15:0];
      end
      return u;
   endfunction

   function automatic longint mag(longint a);
      return a < 0 ? -a : a;
   endfunction

   function automatic cpfb_pkg::frame_type frame_of(wvec_type prev, wvec_type next,
                                                    uvec_type hint, logic present, int idx,
                                                    logic last);
      wvec_type d, w, r, c;
      uvec_type t, n;
      longint dot, ax, ay, az;
      cpfb_pkg::frame_type f;
      for (int i = 0; i < 3; i++) d[i] = $signed(next[i]) - $signed(prev[i]);
      t = unit_vec(d);
      // supplied normal or least aligned world axis
      w = '0;
      if (present) begin
         for (int i = 0; i < 3; i++) w[i] = longint'(hint[i]);
      end else begin
         ax = mag(longint'(t[0]));
         ay = mag(longint'(t[1]));
         az = mag(longint'(t[2]));
         if (ax <= ay && ax <= az) w[0] = cpfb_pkg::UNIT_Q14;
         else if (ay <= az) w[1] = cpfb_pkg::UNIT_Q14;
         else w[2] = cpfb_pkg::UNIT_Q14;
      end
      n = unit_vec(w);
      // gram-schmidt at 2^-42
      dot = 0;
      for (int i = 0; i < 3; i++) dot += longint'(n[i]) * longint'(t[i]);
      for (int i = 0; i < 3; i++) r[i] = longint'(n[i]) * SCALE28 - dot * longint'(t[i]);
      if (mag($signed(r[0])) <= cpfb_pkg::NEAR_MAX && mag($signed(r[1])) <= cpfb_pkg::NEAR_MAX &&
          mag($signed(r[2])) <= cpfb_pkg::NEAR_MAX &&
          $signed(r[0]) * $signed(r[0]) + $signed(r[1]) * $signed(r[1]) +
          $signed(r[2]) * $signed(r[2]) <= cpfb_pkg::NEAR_SQ)
         n = '0;
      else
         n = unit_vec(r);
      c[0] = longint'(t[1]) * n[2] - longint'(t[2]) * n[1];
      c[1] = longint'(t[2]) * n[0] - longint'(t[0]) * n[2];
      c[2] = longint'(t[0]) * n[1] - longint'(t[1]) * n[0];
      f.tan = t;
      f.nrm = n;
      f.bin = unit_vec(c);
      f.index = idx[cpfb_pkg::INDEX_W-1:0];
      f.last = last;
      return f;
   endfunction

   // advance the predictor by one accepted point beat
   task automatic predict_frames(point_beat_type b);
      wvec_type p;
      cpfb_pkg::frame_type f [2];
      int nf, nxt;
      for (int i = 0; i < 3; i++) p[i] = longint'(b.pt[i]);
      nf = 0;
      if (!holding) begin
         if (!b.fin) begin
            prior_pt = p;
            held_pt = p;
            held_nrm = b.nrm;
            held_present = b.present;
            held_idx = 0;
            holding = 1'b1;
         end
      end else begin
         f[0] = frame_of(prior_pt, p, held_nrm, held_present, held_idx, 1'b0);
         nf = 1;
         nxt = held_idx < INDEX_CAP ? held_idx + 1 : INDEX_CAP;
         if (b.fin) begin
            f[1] = frame_of(held_pt, p, b.nrm, b.present, nxt, 1'b1);
            nf = 2;
            holding = 1'b0;
         end else begin
            prior_pt = held_pt;
            held_pt = p;
            held_nrm = b.nrm;
            held_present = b.present;
            held_idx = nxt;
         end
      end
      for (int i = 0; i < nf; i++)
         expected_frames.push_back(b.nwant > 0 ? b.want[i] : f[i]);
   endtask

   function automatic point_beat_type beat(longint x, longint y, longint z, int nx, int ny,
                                           int nz, logic present, logic fin);
      point_beat_type b;
      b.pt[0] = x[31:0];
      b.pt[1] = y[31:0];
      b.pt[2] = z[31:0];
      b.nrm[0] = nx[15:0];
      b.nrm[1] = ny[15:0];
      b.nrm[2] = nz[15:0];
      b.present = present;
      b.fin = fin;
      b.nwant = 0;
      return b;
   endfunction

   // random curve: wide jumps, small walks, repeated points, parallel normals
   task automatic add_curve(int len, int style);
      longint x, y, z;
      int nx, ny, nz, mode;
      logic pres;
      x = $signed($urandom());
      y = $signed($urandom());
      z = $signed($urandom());
      for (int k = 0; k < len; k++) begin
         case (style)
            0: begin
               x = $signed($urandom());
               y = $signed($urandom());
               z = $signed($urandom());
            end
            1: begin
               x = x + $signed($urandom_range(4000, 0)) - 2000;
               y = y + $signed($urandom_range(4000, 0)) - 2000;
               z = z + $signed($urandom_range(4000, 0)) - 2000;
            end
            default: if ($urandom_range(1, 0)) x = x + $urandom_range(65536, 1);
         endcase
         mode = $urandom_range(3, 0);
         nx = $urandom_range(65535, 0) - 32768;
         ny = $urandom_range(65535, 0) - 32768;
         nz = $urandom_range(65535, 0) - 32768;
         if (mode == 3) begin
            nx = 16384;
            ny = 0;
            nz = 0;
         end
         pres = mode != 0;
         plan.push_back(beat(x, y, z, nx, ny, nz, pres, k == len - 1));
      end
      curves_sent++;
   endtask

   task automatic build_plan();
      point_beat_type b;
      cpfb_pkg::frame_type fx;
      int total;
      // single point curve
      plan.push_back(beat(5, 6, 7, 0, 0, 0, 0, 1));
      // straight line along x: fallback normal is y, binormal z
      fx.tan = '0;
      fx.nrm = '0;
      fx.bin = '0;
      fx.tan[0] = cpfb_pkg::UNIT_Q14;
      fx.nrm[1] = cpfb_pkg::UNIT_Q14;
      fx.bin[2] = cpfb_pkg::UNIT_Q14;
      fx.index = 0;
      fx.last = 0;
      plan.push_back(beat(0, 0, 0, 0, 0, 0, 0, 0));
      b = beat(65536, 0, 0, 0, 0, 0, 0, 0);
      b.nwant = 1;
      b.want[0] = fx;
      plan.push_back(b);
      b = beat(131072, 0, 0, 0, 0, 0, 0, 1);
      b.nwant = 2;
      fx.index = 1;
      b.want[0] = fx;
      fx.index = 2;
      fx.last = 1;
      b.want[1] = fx;
      plan.push_back(b);
      // coordinate and normal extremes, zero supplied normal, parallel normal
      plan.push_back(beat(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32767, -32768, 32767,
                          1, 0));
      plan.push_back(beat(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 1, 0));
      plan.push_back(beat(0, 0, 0, 16384, 16384, 16384, 1, 1));
      // repeated point: zero tangent
      plan.push_back(beat(100, 100, 100, 0, 0, 0, 0, 0));
      plan.push_back(beat(100, 100, 100, -32768, -32768, -32768, 1, 0));
      plan.push_back(beat(100, 100, 100, 0, 0, 0, 0, 1));
      // supplied normal along the tangent collapses to zero
      plan.push_back(beat(0, 0, 0, 0, 16384, 0, 1, 0));
      plan.push_back(beat(0, 65536, 0, 0, -16384, 0, 1, 0));
      plan.push_back(beat(0, 131072, 0, 0, 16384, 0, 1, 1));
      // axis ties and diagonal tangents
      plan.push_back(beat(0, 0, 0, 0, 0, 0, 0, 0));
      plan.push_back(beat(65536, 65536, 0, 0, 0, 0, 0, 0));
      plan.push_back(beat(65536, 65536, 65536, 0, 0, 0, 0, 0));
      plan.push_back(beat(0, 0, 65536, 1, -1, 1, 1, 1));
      // random curves
      total = plan.size();
      while (total < RANDOM_BEATS) begin
         if ($urandom_range(9, 0) == 0) begin
            plan.push_back(beat($signed($urandom()), 0, 0, 0, 0, 0, $urandom_range(1, 0), 1));
            total++;
         end else begin
            b.nwant = $urandom_range(30, 2);
            add_curve(b.nwant, $urandom_range(2, 0));
            total += b.nwant;
         end
      end
   endtask

   // receiver stall: random by phase, plus one long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         case (phase)
            0: rsp_stall <= $urandom_range(99, 0) < 75;
            1: rsp_stall <= $urandom_range(99, 0) < 21;
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // frame checker
   always @(posedge clock) begin
      cpfb_pkg::frame_type got, want;
      logic bad;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.tan = {rsp_tangent_z, rsp_tangent_y, rsp_tangent_x};
         got.nrm = {rsp_frame_normal_z, rsp_frame_normal_y, rsp_frame_normal_x};
         got.bin = {rsp_binormal_z, rsp_binormal_y, rsp_binormal_x};
         got.index = rsp_point_index;
         got.last = rsp_last_frame;
         if (expected_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected frame beat: %p", got);
         end else begin
            want = expected_frames.pop_front();
            bad = got.index !== want.index || got.last !== want.last;
            for (int i = 0; i < 3; i++)
               bad |= got.tan[i] !== want.tan[i] || got.nrm[i] !== want.nrm[i] ||
                      got.bin[i] !== want.bin[i];
            if (bad) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("frame mismatch\n  expected %p\n  actual   %p", want, got);
            end
            frames_checked++;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_curve_point_frame_builder_top failed");
         $finish;
      end
   end

   task automatic send_beat(point_beat_type b);
      int pct;
      pct = phase == 0 ? 21 : phase == 1 ? 75 : 0;
      @(negedge clock);
      while ($urandom_range(99, 0) < pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_point_x <= b.pt[0];
      req_point_y <= b.pt[1];
      req_point_z <= b.pt[2];
      req_given_normal_x <= b.nrm[0];
      req_given_normal_y <= b.nrm[1];
      req_given_normal_z <= b.nrm[2];
      req_normal_present <= b.present;
      req_final_point <= b.fin;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_frames(b);
      beats_sent++;
   endtask

   // stimulus
   initial begin
      int n;
      holding = 1'b0;
      held_idx = 0;
      build_plan();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      n = plan.size();
      for (int k = 0; k < n; k++) begin
         if (k == n / 3) begin
            phase = 1;
            hold_left = HOLD_OFF;
         end
         if (k == 2 * n / 3) begin
            // sender pauses until every frame has drained
            @(negedge clock);
            req_valid <= 1'b0;
            wait (expected_frames.size() == 0);
            repeat (50) @(posedge clock);
            phase = 2;
         end
         send_beat(plan[k]);
      end
      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_frames.size() == 0);
      repeat (600) @(posedge clock);
      $display("%0d point beats in %0d random curves, %0d frames checked",
               beats_sent, curves_sent, frames_checked);
      $display("three idle mixes, a %0d cycle receiver hold-off, a drain pause, %0d mismatches",
               HOLD_OFF, mismatches);
      if (mismatches == 0 && expected_frames.size() == 0)
         $display("tb_curve_point_frame_builder_top passed");
      else
         $display("tb_curve_point_frame_builder_top failed");
      $finish;
   end

endmodule
